// ===== design/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// md5_pkg
// Shared types, constants and round tables for the MD5 digest block.
// ----------------------------------------------------------------------------
package md5_pkg;

  // message item: one byte plus framing
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       last;
  } msg_item_t;

  // digest item: one byte of the result
  typedef struct packed {
    logic [7:0] digest_byte;
    logic       digest_last;
  } digest_item_t;

  typedef logic [3:0][31:0] chain_t;

  // top level sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN_LO,
    S_LEN_HI,
    S_START,
    S_WAIT,
    S_OUT
  } state_t;

  // compression unit states
  typedef enum logic [1:0] {
    C_IDLE,
    C_ROUND,
    C_ADD
  } cmp_state_t;

  // control from sequencer to compression unit
  typedef struct packed {
    logic start;
    logic init;
  } cmp_ctrl_t;

  // status from compression unit to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } cmp_stat_t;

  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hefcdab89;
  localparam logic [31:0] IV2 = 32'h98badcfe;
  localparam logic [31:0] IV3 = 32'h10325476;

  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [5:0] LAST_POS    = 6'd63;
  localparam logic [5:0] LAST_ROUND  = 6'd63;
  localparam logic [3:0] LAST_OUT    = 4'd15;
  localparam logic [3:0] WORD_LEN_LO = 4'd14;
  localparam logic [3:0] WORD_LEN_HI = 4'd15;
  localparam int         COUNT_W     = 61;

  // per-round additive constants
  localparam logic [31:0] SINE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // rotate amounts, indexed by round group and round within group of four
  localparam logic [4:0] ROT [4][4] = '{
    '{5'd7, 5'd12, 5'd17, 5'd22},
    '{5'd5, 5'd9,  5'd14, 5'd20},
    '{5'd4, 5'd11, 5'd16, 5'd23},
    '{5'd6, 5'd10, 5'd15, 5'd21}
  };

  // message word used by a round
  function automatic logic [3:0] msg_index(input logic [5:0] rnd);
    logic [3:0] i;
    logic [3:0] g;
    i = rnd[3:0];
    unique case (rnd[5:4])
      2'd0: g = i;
      2'd1: g = 4'((4'd5 * i) + 4'd1);
      2'd2: g = 4'((4'd3 * i) + 4'd5);
      2'd3: g = 4'(4'd7 * i);
      default: g = i;
    endcase
    return g;
  endfunction

  // rotate left by a nonzero amount
  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

endpackage

// ===== design/md5_word_ram.sv =====
// ----------------------------------------------------------------------------
// md5_word_ram
// Sixteen-word block buffer with registered read and per-word valid bits;
// a word never written since the last clear reads as zero.
// ----------------------------------------------------------------------------
module md5_word_ram import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [3:0]  wr_addr,
  input  logic [31:0] wr_data,
  input  logic [3:0]  rd_addr,
  output logic [31:0] rd_data,
  input  logic        clear
);

  logic [31:0] mem [16];
  logic [15:0] valid;
  logic [31:0] rd_q;
  logic        rd_valid;

  // storage write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  // valid bits, write wins over clear
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (clear) begin
        valid <= '0;
      end
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

// ===== design/md5_compress.sv =====
// ----------------------------------------------------------------------------
// md5_compress
// One MD5 round per cycle over the block buffer, then the add into the
// chaining words; holds the chaining words.
// ----------------------------------------------------------------------------
module md5_compress import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmp_ctrl_t   ctrl,
  output cmp_stat_t   stat,
  output logic [3:0]  rd_addr,
  input  logic [31:0] word,
  output chain_t      chain
);

  cmp_state_t  state, state_next;
  logic [5:0]  rnd;
  logic [31:0] a, b, c, d;
  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] b_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      C_IDLE:  if (ctrl.start) state_next = C_ROUND;
      C_ROUND: if (rnd == LAST_ROUND) state_next = C_ADD;
      C_ADD:   state_next = C_IDLE;
      default: state_next = C_IDLE;
    endcase
  end

  // outputs: read address runs one round ahead of the data
  always_comb begin
    stat.busy = (state != C_IDLE);
    stat.done = (state == C_ADD);
    rd_addr   = (state == C_IDLE) ? msg_index(6'd0) : msg_index(rnd + 6'd1);
  end

  // round function
  always_comb begin
    unique case (rnd[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      2'd3: f = c ^ (b | ~d);
      default: f = b ^ c ^ d;
    endcase
    sum    = a + f + SINE[rnd] + word;
    b_next = b + rotl32(sum, ROT[rnd[5:4]][rnd[1:0]]);
  end

  // working variables and round counter
  always_ff @(posedge clk) begin
    if (state == C_IDLE && ctrl.start) begin
      a   <= chain[0];
      b   <= chain[1];
      c   <= chain[2];
      d   <= chain[3];
      rnd <= '0;
    end else if (state == C_ROUND) begin
      a   <= d;
      d   <= c;
      c   <= b;
      b   <= b_next;
      rnd <= rnd + 6'd1;
    end
  end

  // chaining words
  always_ff @(posedge clk) begin
    if (rst || ctrl.init) begin
      chain <= {IV3, IV2, IV1, IV0};
    end else if (state == C_ADD) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
    end
  end

  // a start only arrives while idle
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |-> state == C_IDLE)
    else $error("compression started while busy");

  // the last round is followed by the add
  a_round_to_add: assert property (@(posedge clk) disable iff (rst)
    (state == C_ROUND && rnd == LAST_ROUND) |=> state == C_ADD)
    else $error("add did not follow last round");

  // the chain is not reloaded during a compression
  a_no_init_busy: assert property (@(posedge clk) disable iff (rst)
    ctrl.init |-> state == C_IDLE)
    else $error("chain reloaded while compressing");

endmodule

// ===== design/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// md5_message_digest
// MD5 digest of a byte stream, one message byte per item, 16-byte result.
// ----------------------------------------------------------------------------
// Usage:
//   msg channel: msg_item carries data_byte, byte_present and last. An item is
//   taken when msg_valid is high and msg_stall is low. An item with last set
//   closes the message; byte_present low with last set closes it without a
//   byte (an empty message is such an item alone).
//   digest channel: after a closing item, sixteen items leave on digest_item,
//   chaining word 0 low byte first, digest_last on the sixteenth.
// Throughput and flow:
//   byte items are taken one per cycle while msg_stall is low. The 64th byte
//   of a block starts the compression (one start step, 64 rounds at one per
//   cycle through the single round unit, one add), during which msg_stall is high.
//   A closing item adds a pad write, two length writes and one or two
//   compressions, then the sixteen digest items at one per cycle while
//   digest_stall is low; a stall holds the item.
// Reset: chaining words return to the initial vector, byte count and buffer
//   valid bits clear at once; there is no clearing pass.
// ----------------------------------------------------------------------------
module md5_message_digest import md5_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         msg_valid,
  output logic         msg_stall,
  input  msg_item_t    msg_item,
  output logic         digest_valid,
  input  logic         digest_stall,
  output digest_item_t digest_item
);

  state_t              state, state_next;
  state_t              resume, resume_next;
  logic [COUNT_W-1:0]  count;
  logic [31:0]         word_acc;
  logic [3:0]          out_cnt;
  logic [5:0]          pos;
  logic [31:0]         byte_word;
  logic                msg_take;
  logic                digest_take;
  logic                wr_en;
  logic [3:0]          wr_addr;
  logic [31:0]         wr_data;
  logic [3:0]          rd_addr;
  logic [31:0]         rd_data;
  cmp_ctrl_t           cmp_ctrl;
  cmp_stat_t           cmp_stat;
  chain_t              chain;

  assign pos         = count[5:0];
  assign msg_take    = msg_valid && !msg_stall;
  assign digest_take = digest_valid && !digest_stall;
  assign byte_word   = word_acc | (32'(msg_item.data_byte) << {pos[1:0], 3'b000});

  md5_word_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .clear   (cmp_stat.done)
  );

  md5_compress u_cmp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (cmp_ctrl),
    .stat    (cmp_stat),
    .rd_addr (rd_addr),
    .word    (rd_data),
    .chain   (chain)
  );

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      resume <= S_IDLE;
    end else begin
      state  <= state_next;
      resume <= resume_next;
    end
  end

  // next state
  always_comb begin
    state_next  = state;
    resume_next = resume;
    unique case (state)
      S_IDLE: begin
        if (msg_take) begin
          if (msg_item.byte_present && pos == LAST_POS) begin
            state_next  = S_START;
            resume_next = msg_item.last ? S_PAD : S_IDLE;
          end else if (msg_item.last) begin
            state_next = S_PAD;
          end
        end
      end
      S_PAD: begin
        if (pos[5:3] == 3'b111) begin
          state_next  = S_START;
          resume_next = S_LEN_LO;
        end else begin
          state_next = S_LEN_LO;
        end
      end
      S_LEN_LO: state_next = S_LEN_HI;
      S_LEN_HI: begin
        state_next  = S_START;
        resume_next = S_OUT;
      end
      S_START: state_next = S_WAIT;
      S_WAIT:  if (cmp_stat.done) state_next = resume;
      S_OUT:   if (digest_take && out_cnt == LAST_OUT) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and buffer writes
  always_comb begin
    msg_stall      = (state != S_IDLE);
    digest_valid   = (state == S_OUT);
    cmp_ctrl.start = (state == S_START);
    cmp_ctrl.init  = digest_take && out_cnt == LAST_OUT;
    wr_en          = 1'b0;
    wr_addr        = pos[5:2];
    wr_data        = byte_word;
    unique case (state)
      S_IDLE: begin
        wr_en = msg_take && msg_item.byte_present && pos[1:0] == 2'd3;
      end
      S_PAD: begin
        wr_en   = 1'b1;
        wr_data = word_acc | (32'(PAD_BYTE) << {pos[1:0], 3'b000});
      end
      S_LEN_LO: begin
        wr_en   = 1'b1;
        wr_addr = WORD_LEN_LO;
        wr_data = {count[28:0], 3'b000};
      end
      S_LEN_HI: begin
        wr_en   = 1'b1;
        wr_addr = WORD_LEN_HI;
        wr_data = count[60:29];
      end
      S_START, S_WAIT, S_OUT: wr_en = 1'b0;
      default: wr_en = 1'b0;
    endcase
  end

  // digest byte select
  always_comb begin
    digest_item.digest_byte = chain[out_cnt[3:2]][{out_cnt[1:0], 3'b000} +: 8];
    digest_item.digest_last = (out_cnt == LAST_OUT);
  end

  // byte count, partial word and output counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      word_acc <= '0;
      out_cnt  <= '0;
    end else begin
      if (state == S_IDLE && msg_take && msg_item.byte_present) begin
        count    <= count + COUNT_W'(1);
        word_acc <= (pos[1:0] == 2'd3) ? '0 : byte_word;
      end
      if (state == S_PAD) begin
        word_acc <= '0;
      end
      if (digest_take) begin
        out_cnt <= out_cnt + 4'd1;
        if (out_cnt == LAST_OUT) begin
          count <= '0;
        end
      end
    end
  end

  // compression only finishes while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    cmp_stat.done |-> state == S_WAIT)
    else $error("compression finished outside wait");

  // the final digest item returns the block to idle with a fresh count
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (digest_take && digest_item.digest_last) |=> (state == S_IDLE && count == '0))
    else $error("block not idle after last digest item");

  // no partial word is left over while the digest goes out
  a_acc_clear_out: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (word_acc == '0 && !cmp_stat.busy))
    else $error("stale buffer state during digest output");

endmodule
